// ===== rtl/core/bac_pkg.sv =====
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types, constants and step functions for the arc control point block.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_BITS     = 53;
  localparam int MUL_LAT      = 4;
  localparam int MUL_AW       = 57;
  localparam int MUL_BW       = 32;
  localparam int MUL_PW       = 58;
  localparam int MUL_LO       = 28;
  localparam int UNIT_SHIFT   = 30;
  localparam int LAT = (CORDIC_STEPS + 1) + 1 + (DIV_BITS + 1) + 1
                     + 3 * (MUL_LAT + 1);

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [DIV_BITS-1:0] HANDLE_MAX = {1'b1, {(DIV_BITS-1){1'b0}}};

  localparam logic [1:0] QUAD0 = 2'd0;
  localparam logic [1:0] QUAD1 = 2'd1;
  localparam logic [1:0] QUAD2 = 2'd2;

  localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } cord_t;

  typedef struct packed {
    logic signed [33:0] cs;
    logic signed [33:0] sn;
  } sincos_t;

  typedef struct packed {
    logic signed [33:0] rc;
    logic signed [33:0] rs;
    logic signed [33:0] sc;
    logic signed [33:0] ss;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rad;
  } side_t;

  typedef struct packed {
    logic [34:0]          rem;
    logic [DIV_BITS-1:0]  nlow;
    logic [34:0]          ud;
    logic [DIV_BITS-1:0]  q;
    logic                 ovf;
    logic                 neg;
  } div_t;

  function automatic cord_t cord_step(cord_t c, logic [4:0] i);
    cord_t n;
    n = c;
    if (!c.z[32]) begin
      n.x = c.x - (c.y >>> i);
      n.y = c.y + (c.x >>> i);
      n.z = c.z - 33'(ATAN_TABLE[i]);
    end else begin
      n.x = c.x + (c.y >>> i);
      n.y = c.y - (c.x >>> i);
      n.z = c.z + 33'(ATAN_TABLE[i]);
    end
    return n;
  endfunction

  function automatic sincos_t fold(cord_t c);
    sincos_t s;
    case (c.quad)
      QUAD0: begin
        s.cs = c.x;
        s.sn = c.y;
      end
      QUAD1: begin
        s.cs = -c.y;
        s.sn = c.x;
      end
      QUAD2: begin
        s.cs = -c.x;
        s.sn = -c.y;
      end
      default: begin
        s.cs = c.y;
        s.sn = -c.x;
      end
    endcase
    return s;
  endfunction

  function automatic div_t div_step(div_t d);
    div_t       n;
    logic [35:0] rem2;
    n = d;
    rem2 = {d.rem, d.nlow[DIV_BITS-1]};
    if (rem2 >= {1'b0, d.ud}) begin
      n.rem = 35'(rem2 - {1'b0, d.ud});
      n.q   = {d.q[DIV_BITS-2:0], 1'b1};
    end else begin
      n.rem = rem2[34:0];
      n.q   = {d.q[DIV_BITS-2:0], 1'b0};
    end
    n.nlow = d.nlow << 1;
    return n;
  endfunction

endpackage

// ===== rtl/core/bac_mulq.sv =====
// ----------------------------------------------------------------------------
// bac_mulq
// Signed multiply, product shifted right and rounded half away from zero.
// Four register stages: magnitudes, split partial products, sum, sign.
// ----------------------------------------------------------------------------
module bac_mulq (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [bac_pkg::MUL_AW-1:0] a,
  input  logic signed [bac_pkg::MUL_BW-1:0] b,
  output logic signed [bac_pkg::MUL_PW-1:0] p
);
  import bac_pkg::*;

  localparam int LOW_W = MUL_LO + MUL_BW;
  localparam int HI_W  = MUL_AW - MUL_LO + MUL_BW;
  localparam int SUM_W = HI_W + MUL_LO + 1;
  localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (UNIT_SHIFT - 1);

  logic              neg1_r, neg2_r, neg3_r;
  logic [MUL_AW-1:0] am_r;
  logic [MUL_BW-1:0] bm_r;
  logic [LOW_W-1:0]  plo_r;
  logic [HI_W-1:0]   phi_r;
  logic [SUM_W-1:0]  sum_r;
  logic [MUL_PW-1:0] p_r;
  logic [MUL_PW-1:0] val;

  assign val = MUL_PW'(sum_r >> UNIT_SHIFT);
  assign p   = p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[MUL_AW-1] ^ b[MUL_BW-1];
      am_r   <= a[MUL_AW-1] ? MUL_AW'(-a) : MUL_AW'(a);
      bm_r   <= b[MUL_BW-1] ? MUL_BW'(-b) : MUL_BW'(b);
      neg2_r <= neg1_r;
      plo_r  <= LOW_W'(am_r[MUL_LO-1:0]) * LOW_W'(bm_r);
      phi_r  <= HI_W'(am_r[MUL_AW-1:MUL_LO]) * HI_W'(bm_r);
      neg3_r <= neg2_r;
      sum_r  <= {1'b0, phi_r, {MUL_LO{1'b0}}} + SUM_W'(plo_r) + ROUND;
      p_r    <= neg3_r ? -val : val;
    end
  end

endmodule

// ===== rtl/core/bezier_arc_control_points.sv =====
// ----------------------------------------------------------------------------
// bezier_arc_control_points
// Four cubic Bezier control points of a circular arc from centre, radius,
// start and span angle; Q16.16 coordinates, saturated.
// Pipeline: 30 CORDIC stages, 53 restoring divider stages for the handle length,
// then three multiply stages.
// Throughput: one transaction per cycle; a stall on the output holds the
// whole pipeline. Reset (synchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
module bezier_arc_control_points (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, arc_radius, start_turn, span_turn
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y
  output logic [255:0] out_tdata
);
  import bac_pkg::*;

  localparam logic signed [58:0] OUT_MAX = 59'sh7fffffff;
  localparam logic signed [58:0] OUT_MIN = -OUT_MAX - 59'sd1;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // input decode and quadrant fold
  side_t              in_side;
  logic [15:0]        start;
  logic signed [31:0] span_w;
  logic [31:0]        ang [3];
  cord_t              cord_init [3];

  always_comb begin
    logic [31:0] sum;
    logic [31:0] res;
    in_side.cx  = in_tdata[31:0];
    in_side.cy  = in_tdata[63:32];
    in_side.rad = in_tdata[94:64];
    start       = in_tdata[110:95];
    span_w      = 32'($signed(in_tdata[127:111]));
    ang[0]      = 32'(start) << (32 - ANGLE_BITS);
    ang[1]      = span_w << (32 - ANGLE_BITS);
    ang[2]      = span_w << (30 - ANGLE_BITS);
    for (int u = 0; u < 3; u++) begin
      sum               = ang[u] + 32'h2000_0000;
      res               = ang[u] - {sum[31:30], 30'b0};
      cord_init[u].x    = CORDIC_X0;
      cord_init[u].y    = '0;
      cord_init[u].z    = 33'($signed(res));
      cord_init[u].quad = sum[31:30];
    end
  end

  // CORDIC pipeline: unit 0 start angle, 1 span, 2 quarter span
  cord_t cord_r [CORDIC_STEPS+1][3];
  side_t sd_c_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_c_r[0] <= in_side;
      for (int u = 0; u < 3; u++) begin
        cord_r[0][u] <= cord_init[u];
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        sd_c_r[i+1] <= sd_c_r[i];
        for (int u = 0; u < 3; u++) begin
          cord_r[i+1][u] <= cord_step(cord_r[i][u], 5'(i));
        end
      end
    end
  end

  // fold back to full circle
  trig_t   tr_f_r;
  sincos_t qt_f_r;
  side_t   sd_f_r;

  always_ff @(posedge clk) begin
    sincos_t a;
    sincos_t b;
    a = fold(cord_r[CORDIC_STEPS][0]);
    b = fold(cord_r[CORDIC_STEPS][1]);
    if (en) begin
      tr_f_r <= '{rc: a.cs, rs: a.sn, sc: b.cs, ss: b.sn};
      qt_f_r <= fold(cord_r[CORDIC_STEPS][2]);
      sd_f_r <= sd_c_r[CORDIC_STEPS];
    end
  end

  // handle length divider setup
  div_t        div_init;
  logic [33:0] aqs, aqc;
  logic [34:0] ud0;
  logic [63:0] num0;

  always_comb begin
    aqs           = qt_f_r.sn[33] ? 34'(-qt_f_r.sn) : 34'(qt_f_r.sn);
    aqc           = qt_f_r.cs[33] ? 34'(-qt_f_r.cs) : 34'(qt_f_r.cs);
    ud0           = {aqc, 1'b0} + 35'(aqc);
    num0          = {aqs[31:0], 32'b0} + 64'(ud0 >> 1);
    div_init.rem  = 35'(num0 >> DIV_BITS);
    div_init.nlow = num0[DIV_BITS-1:0];
    div_init.ud   = ud0;
    div_init.q    = '0;
    div_init.ovf  = (num0 >> DIV_BITS) >= 64'(ud0);
    div_init.neg  = qt_f_r.sn[33] ^ qt_f_r.cs[33];
  end

  div_t  div_r  [DIV_BITS+1];
  trig_t tr_d_r [DIV_BITS+1];
  side_t sd_d_r [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0]  <= div_init;
      tr_d_r[0] <= tr_f_r;
      sd_d_r[0] <= sd_f_r;
      for (int k = 0; k < DIV_BITS; k++) begin
        div_r[k+1]  <= div_step(div_r[k]);
        tr_d_r[k+1] <= tr_d_r[k];
        sd_d_r[k+1] <= sd_d_r[k];
      end
    end
  end

  // signed, saturated handle
  logic signed [MUL_AW-1:0] l_l_r;
  trig_t                    tr_l_r;
  side_t                    sd_l_r;

  always_ff @(posedge clk) begin
    logic [DIV_BITS-1:0] mag;
    if (div_r[DIV_BITS].ovf || div_r[DIV_BITS].q > HANDLE_MAX) begin
      mag = HANDLE_MAX;
    end else begin
      mag = div_r[DIV_BITS].q;
    end
    if (en) begin
      l_l_r  <= div_r[DIV_BITS].neg ? -MUL_AW'(mag) : MUL_AW'(mag);
      tr_l_r <= tr_d_r[DIV_BITS];
      sd_l_r <= sd_d_r[DIV_BITS];
    end
  end

  // l * sin s, l * cos s
  logic signed [MUL_AW-1:0] ma_a [2];
  logic signed [MUL_BW-1:0] ma_b [2];
  logic signed [MUL_PW-1:0] pa   [2];

  assign ma_a[0] = l_l_r;
  assign ma_b[0] = MUL_BW'(tr_l_r.ss);
  assign ma_a[1] = l_l_r;
  assign ma_b[1] = MUL_BW'(tr_l_r.sc);

  for (genvar g = 0; g < 2; g++) begin : g_ma
    bac_mulq u_mul (.clk(clk), .en(en), .a(ma_a[g]), .b(ma_b[g]), .p(pa[g]));
  end

  logic signed [MUL_AW-1:0] l_a_r  [MUL_LAT];
  trig_t                    tr_a_r [MUL_LAT];
  side_t                    sd_a_r [MUL_LAT];
  logic signed [MUL_AW-1:0] ux_u_r, uy_u_r, l_u_r;
  trig_t                    tr_u_r;
  side_t                    sd_u_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l_a_r[0]  <= l_l_r;
      tr_a_r[0] <= tr_l_r;
      sd_a_r[0] <= sd_l_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        l_a_r[k]  <= l_a_r[k-1];
        tr_a_r[k] <= tr_a_r[k-1];
        sd_a_r[k] <= sd_a_r[k-1];
      end
      ux_u_r <= MUL_AW'(tr_a_r[MUL_LAT-1].sc + pa[0]);
      uy_u_r <= MUL_AW'(tr_a_r[MUL_LAT-1].ss - pa[1]);
      l_u_r  <= l_a_r[MUL_LAT-1];
      tr_u_r <= tr_a_r[MUL_LAT-1];
      sd_u_r <= sd_a_r[MUL_LAT-1];
    end
  end

  // rotation products
  logic signed [MUL_AW-1:0] mb_a [10];
  logic signed [MUL_BW-1:0] mb_b [10];
  logic signed [MUL_PW-1:0] pb   [10];
  logic signed [MUL_AW-1:0] sc_w, ss_w;
  logic signed [MUL_BW-1:0] rc_w, rs_w;

  always_comb begin
    sc_w = MUL_AW'(tr_u_r.sc);
    ss_w = MUL_AW'(tr_u_r.ss);
    rc_w = MUL_BW'(tr_u_r.rc);
    rs_w = MUL_BW'(tr_u_r.rs);
    mb_a[0] = l_u_r;  mb_b[0] = rs_w;
    mb_a[1] = l_u_r;  mb_b[1] = rc_w;
    mb_a[2] = ux_u_r; mb_b[2] = rc_w;
    mb_a[3] = uy_u_r; mb_b[3] = rs_w;
    mb_a[4] = ux_u_r; mb_b[4] = rs_w;
    mb_a[5] = uy_u_r; mb_b[5] = rc_w;
    mb_a[6] = sc_w;   mb_b[6] = rc_w;
    mb_a[7] = ss_w;   mb_b[7] = rs_w;
    mb_a[8] = sc_w;   mb_b[8] = rs_w;
    mb_a[9] = ss_w;   mb_b[9] = rc_w;
  end

  for (genvar g = 0; g < 10; g++) begin : g_mb
    bac_mulq u_mul (.clk(clk), .en(en), .a(mb_a[g]), .b(mb_b[g]), .p(pb[g]));
  end

  trig_t                    tr_b_r [MUL_LAT];
  side_t                    sd_b_r [MUL_LAT];
  logic signed [MUL_AW-1:0] r_r    [8];
  side_t                    sd_r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tr_b_r[0] <= tr_u_r;
      sd_b_r[0] <= sd_u_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        tr_b_r[k] <= tr_b_r[k-1];
        sd_b_r[k] <= sd_b_r[k-1];
      end
      r_r[0] <= MUL_AW'(tr_b_r[MUL_LAT-1].rc);
      r_r[1] <= MUL_AW'(tr_b_r[MUL_LAT-1].rs);
      r_r[2] <= MUL_AW'(tr_b_r[MUL_LAT-1].rc - pb[0]);
      r_r[3] <= MUL_AW'(tr_b_r[MUL_LAT-1].rs + pb[1]);
      r_r[4] <= MUL_AW'(pb[2] - pb[3]);
      r_r[5] <= MUL_AW'(pb[4] + pb[5]);
      r_r[6] <= MUL_AW'(pb[6] - pb[7]);
      r_r[7] <= MUL_AW'(pb[8] + pb[9]);
      sd_r_r <= sd_b_r[MUL_LAT-1];
    end
  end

  // radius scale, centre offset, saturation
  logic signed [MUL_BW-1:0] rad_w;
  logic signed [MUL_PW-1:0] pc [8];

  assign rad_w = {1'b0, sd_r_r.rad};

  for (genvar g = 0; g < 8; g++) begin : g_mc
    bac_mulq u_mul (.clk(clk), .en(en), .a(r_r[g]), .b(rad_w), .p(pc[g]));
  end

  side_t        sd_s_r [MUL_LAT];
  logic [255:0] out_tdata_r;

  assign out_tdata = out_tdata_r;

  always_ff @(posedge clk) begin
    logic signed [58:0] v;
    if (en) begin
      sd_s_r[0] <= sd_r_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        sd_s_r[k] <= sd_s_r[k-1];
      end
      for (int k = 0; k < 8; k++) begin
        v = 59'(pc[k]) + ((k % 2 == 0) ? 59'(sd_s_r[MUL_LAT-1].cx)
                                       : 59'(sd_s_r[MUL_LAT-1].cy));
        if (v > OUT_MAX) begin
          out_tdata_r[32*k +: 32] <= 32'h7fff_ffff;
        end else if (v < OUT_MIN) begin
          out_tdata_r[32*k +: 32] <= 32'h8000_0000;
        end else begin
          out_tdata_r[32*k +: 32] <= v[31:0];
        end
      end
    end
  end

endmodule

// ===== rtl/core/bac_checker.sv =====
// ----------------------------------------------------------------------------
// bac_checker
// Port-level checks for the arc control point block.
// ----------------------------------------------------------------------------
module bac_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result transaction changed");

  // pipeline moves exactly when the result slot is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output slot");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // nothing new appears at the output while stalled
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_tready |=> !out_tvalid)
    else $error("result appeared without pipeline advance");

endmodule

bind bezier_arc_control_points bac_checker u_bac_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);
